/* rtl/rmm_pkg.sv */
// shared types, register indexes, state codes and rounding helpers of the ring modulator mix
package rmm_pkg;

    localparam int NUM_CHANNELS_DEF = 2;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_COS       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_SIN       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CARRIER_SHAPE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WET_MIX       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WET_GAIN      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BYPASS_ENABLE = 3'd6;

    // carrier shapes, any other code selects the sine
    localparam logic [1:0] SHAPE_TRIANGLE = 2'd1;
    localparam logic [1:0] SHAPE_SQUARE   = 2'd2;

    // input kinds
    localparam logic KIND_AUDIO   = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    localparam logic signed [31:0] Q30_ONE   = 32'sh4000_0000;
    localparam logic signed [32:0] CARR_POS  = 33'sh0_4000_0000;
    localparam logic signed [32:0] CARR_NEG  = 33'sh1_C000_0000;
    localparam logic        [16:0] UNITY_Q16 = 17'd65536;

    // per-channel state word: phase, phasor real, phasor imaginary
    localparam int STATE_W = 96;
    localparam logic [STATE_W-1:0] STATE_RESET = {32'd0, Q30_ONE, 32'd0};

    typedef struct packed {
        logic               kind;
        logic               channel;
        logic signed [23:0] sample_in;
    } in_item_t;

    typedef struct packed {
        logic               channel_out;
        logic signed [23:0] sample_out;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_ROT_RC,
        ST_ROT_IS,
        ST_ROT_IC,
        ST_ROT_RS,
        ST_ROT_SUM,
        ST_ROT_IMAG,
        ST_WET,
        ST_DRY,
        ST_MIXW,
        ST_GAIN_LO,
        ST_GAIN_HI,
        ST_ACC,
        ST_FINISH,
        ST_OUT
    } rmm_state_t;

    // round half up then floor shift by 30
    function automatic logic signed [33:0] rnd30(input logic signed [63:0] x);
        logic signed [63:0] t;
        t = x + 64'sd536870912;
        return t[63:30];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
            r = v[31:0];
        end else if (v[33]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [33:0] v);
        logic signed [23:0] r;
        if (v[33:23] == 11'h000 || v[33:23] == 11'h7FF) begin
            r = v[23:0];
        end else if (v[33]) begin
            r = 24'sh80_0000;
        end else begin
            r = 24'sh7F_FFFF;
        end
        return r;
    endfunction

endpackage

/* rtl/rmm_ram.sv */
// generic single-write, single-read ram with registered read data
module rmm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/ring_modulator_mix.sv */
// top level of the ring modulator mix: sequencer, shared multiplier and carrier state ram
//
//  channel | ports                              | carries
//  --------+------------------------------------+-----------------------------------
//  input   | s_valid, s_ready, s_item           | kind, channel, sample_in
//  result  | m_valid, m_ready, m_item           | channel_out, sample_out
//  config  | cfg_wr_en, cfg_idx, cfg_wdata      | seven registers, write only
//
// an active audio item runs through every sequencer state before the next accept: one 33x33
// multiplier is shared by the nine products of the rotation and the mix, one per cycle
// a bypassed or absent-channel item goes straight to the output state, a restart item is consumed in idle, no result
// restart and reset clear per-channel valid bits at once, so no clearing pass is needed
// a result waits in the output register; the next item is taken while it waits,
// only a second result stalls the sequencer until the first one is taken
module ring_modulator_mix #(
    parameter int NUM_CHANNELS = rmm_pkg::NUM_CHANNELS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // input items
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  rmm_pkg::in_item_t                    s_item,
    // result items
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output rmm_pkg::out_item_t                   m_item,
    // configuration writes
    input  logic                                 cfg_wr_en,
    input  logic [rmm_pkg::CFG_IDX_W-1:0]        cfg_idx,
    input  logic [rmm_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

    import rmm_pkg::*;

    localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    // configuration registers
    logic        [30:0] phase_step_reg;
    logic signed [31:0] rot_cos_reg;
    logic signed [31:0] rot_sin_reg;
    logic        [1:0]  shape_reg;
    logic        [16:0] wet_mix_reg;
    logic        [16:0] wet_gain_reg;
    logic               bypass_reg;

    // sequencer
    rmm_state_t state_reg, state_next;

    // per-channel valid bits, clear means the channel reads its reset state
    logic [NUM_CHANNELS-1:0] chan_valid_reg;

    // captured item
    in_item_t    item_reg;
    logic [AW-1:0] addr_reg;

    // datapath
    logic        [31:0] ph_reg;
    logic signed [31:0] re_reg;
    logic signed [31:0] im_reg;
    logic signed [31:0] nre_reg;
    logic signed [31:0] nim_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] acc_reg;
    logic signed [25:0] wet_reg;
    logic signed [21:0] wm_hi_reg;
    logic signed [23:0] res_reg;

    // output register
    logic      m_valid_reg;
    out_item_t m_item_reg;

    logic                 s_accept;
    logic                 chan_present;
    logic [AW-1:0]        s_addr;
    logic [STATE_W-1:0]   ram_rdata;
    logic [STATE_W-1:0]   state_word;
    logic                 ram_we;
    logic [16:0]          mix_eff;
    logic [16:0]          gain_eff;
    logic [16:0]          dry_w;
    logic [32:0]          tri_abs;
    logic signed [32:0]   carrier;
    logic signed [32:0]   mul_a;
    logic signed [32:0]   mul_b;
    logic signed [65:0]   mul_p;
    logic                 out_load;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign s_addr   = AW'(s_item.channel);
    assign chan_present = (32'(s_item.channel) < NUM_CHANNELS);

    // ---------------------------------------------------------------- config
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_step_reg <= '0;
            rot_cos_reg    <= Q30_ONE;
            rot_sin_reg    <= '0;
            shape_reg      <= '0;
            wet_mix_reg    <= UNITY_Q16;
            wet_gain_reg   <= 17'd16384;
            bypass_reg     <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_idx)
                REG_PHASE_STEP:    phase_step_reg <= cfg_wdata[30:0];
                REG_ROT_COS:       rot_cos_reg    <= cfg_wdata;
                REG_ROT_SIN:       rot_sin_reg    <= cfg_wdata;
                REG_CARRIER_SHAPE: shape_reg      <= cfg_wdata[1:0];
                REG_WET_MIX:       wet_mix_reg    <= cfg_wdata[16:0];
                REG_WET_GAIN:      wet_gain_reg   <= cfg_wdata[16:0];
                REG_BYPASS_ENABLE: bypass_reg     <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // mix and gain above unity clamp to unity
    assign mix_eff  = (wet_mix_reg  > UNITY_Q16) ? UNITY_Q16 : wet_mix_reg;
    assign gain_eff = (wet_gain_reg > UNITY_Q16) ? UNITY_Q16 : wet_gain_reg;
    assign dry_w    = UNITY_Q16 - mix_eff;

    // ---------------------------------------------------------------- state ram
    assign ram_we = (state_reg == ST_WET);

    rmm_ram #(
        .WIDTH (STATE_W),
        .DEPTH (NUM_CHANNELS)
    ) u_state_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (addr_reg),
        .wr_data ({ph_reg, nre_reg, nim_reg}),
        .rd_addr (s_addr),
        .rd_data (ram_rdata)
    );

    // a never-written or restarted channel reads as phase zero, phasor one
    assign state_word = chan_valid_reg[addr_reg] ? ram_rdata : STATE_RESET;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chan_valid_reg <= '0;
        end else if (s_accept && s_item.kind == KIND_RESTART) begin
            chan_valid_reg <= '0;
        end else if (ram_we) begin
            chan_valid_reg[addr_reg] <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept && s_item.kind == KIND_AUDIO) begin
                    // bypass and absent channels skip the math, state untouched
                    if (bypass_reg || !chan_present) begin
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:     state_next = ST_ROT_RC;
            ST_ROT_RC:   state_next = ST_ROT_IS;
            ST_ROT_IS:   state_next = ST_ROT_IC;
            ST_ROT_IC:   state_next = ST_ROT_RS;
            ST_ROT_RS:   state_next = ST_ROT_SUM;
            ST_ROT_SUM:  state_next = ST_ROT_IMAG;
            ST_ROT_IMAG: state_next = ST_WET;
            ST_WET:      state_next = ST_DRY;
            ST_DRY:      state_next = ST_MIXW;
            ST_MIXW:     state_next = ST_GAIN_LO;
            ST_GAIN_LO:  state_next = ST_GAIN_HI;
            ST_GAIN_HI:  state_next = ST_ACC;
            ST_ACC:      state_next = ST_FINISH;
            ST_FINISH:   state_next = ST_OUT;
            ST_OUT: begin
                // wait for a free output register
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- carrier
    // triangle: |phase - half cycle| - quarter amplitude
    assign tri_abs = ph_reg[31] ? {2'b00, ph_reg[30:0]}
                                : 33'h0_8000_0000 - {2'b00, ph_reg[30:0]};

    always_comb begin
        case (shape_reg)
            SHAPE_TRIANGLE: carrier = $signed(tri_abs) - CARR_POS;
            SHAPE_SQUARE:   carrier = ph_reg[31] ? CARR_NEG : CARR_POS;
            default:        carrier = {nim_reg[31], nim_reg};
        endcase
    end

    // ---------------------------------------------------------------- shared multiplier
    always_comb begin
        case (state_reg)
            ST_ROT_RC: begin
                mul_a = {re_reg[31], re_reg};
                mul_b = {rot_cos_reg[31], rot_cos_reg};
            end
            ST_ROT_IS: begin
                mul_a = {im_reg[31], im_reg};
                mul_b = {rot_sin_reg[31], rot_sin_reg};
            end
            ST_ROT_IC: begin
                mul_a = {im_reg[31], im_reg};
                mul_b = {rot_cos_reg[31], rot_cos_reg};
            end
            ST_ROT_RS: begin
                mul_a = {re_reg[31], re_reg};
                mul_b = {rot_sin_reg[31], rot_sin_reg};
            end
            ST_WET: begin
                mul_a = {{9{item_reg.sample_in[23]}}, item_reg.sample_in};
                mul_b = carrier;
            end
            ST_DRY: begin
                mul_a = {{9{item_reg.sample_in[23]}}, item_reg.sample_in};
                mul_b = {16'd0, dry_w};
            end
            ST_MIXW: begin
                mul_a = {{7{wet_reg[25]}}, wet_reg};
                mul_b = {16'd0, mix_eff};
            end
            ST_GAIN_LO: begin
                // low 22 bits of wet*mix, unsigned
                mul_a = {11'd0, prod_reg[21:0]};
                mul_b = {16'd0, gain_eff};
            end
            ST_GAIN_HI: begin
                mul_a = {{11{wm_hi_reg[21]}}, wm_hi_reg};
                mul_b = {16'd0, gain_eff};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // ---------------------------------------------------------------- datapath
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg <= s_item;
            addr_reg <= s_addr;
            res_reg  <= s_item.sample_in;
        end
        prod_reg <= mul_p[63:0];
        case (state_reg)
            ST_READ: begin
                ph_reg <= state_word[95:64];
                re_reg <= state_word[63:32];
                im_reg <= state_word[31:0];
            end
            // re' = re*c - im*s, im' = im*c + re*s, accumulator wraps
            ST_ROT_IS: acc_reg <= prod_reg;
            ST_ROT_IC: acc_reg <= acc_reg - prod_reg;
            ST_ROT_RS: begin
                nre_reg <= sat32(rnd30(acc_reg));
                acc_reg <= prod_reg;
            end
            ST_ROT_SUM: begin
                acc_reg <= acc_reg + prod_reg;
                ph_reg  <= ph_reg + {1'b0, phase_step_reg};
            end
            ST_ROT_IMAG: nim_reg <= sat32(rnd30(acc_reg));
            ST_DRY:      wet_reg <= 26'(rnd30(prod_reg));
            // dry term: sample*(1-mix) in Q.30
            ST_MIXW:     acc_reg <= prod_reg <<< 14;
            ST_GAIN_LO:  wm_hi_reg <= prod_reg[43:22];
            ST_GAIN_HI:  acc_reg <= acc_reg + prod_reg;
            ST_ACC:      acc_reg <= acc_reg + (prod_reg <<< 22);
            ST_FINISH:   res_reg <= sat24(rnd30(acc_reg));
            default: ;
        endcase
    end

    // ---------------------------------------------------------------- output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_item_reg.channel_out <= item_reg.channel;
            m_item_reg.sample_out  <= res_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // ---------------------------------------------------------------- assertions
    // a restart item leaves every channel at its reset state
    a_restart_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_item.kind == KIND_RESTART) |=> (chan_valid_reg == '0))
        else $error("restart did not clear channel valid bits");

    // the ram read is looked at only in the cycle right after an accept
    a_read_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |-> $past(s_accept))
        else $error("ram data used without a fresh read");

    // bypassed items carry the sample unchanged
    a_bypass_passthru: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_item.kind == KIND_AUDIO && bypass_reg)
        |=> (state_reg == ST_OUT && res_reg == item_reg.sample_in))
        else $error("bypass result differs from input sample");

    // a fresh result belongs to the captured item's channel
    a_out_channel: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> (m_item_reg.channel_out == item_reg.channel))
        else $error("result channel mismatch");

endmodule
